/* hw/rtl/tphr_pkg.sv */
// Shared definitions for the timestamped pose history ring.
// Opcodes, result status codes, register indexes and reset defaults.
// No dependencies.
package tphr_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int STAMP_BITS_DEF = 48;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int NUM_VALUES = 9;

  // position of each value inside a stored record
  localparam int F_EAST = 0;
  localparam int F_NORTH = 1;
  localparam int F_HEADING = 2;
  localparam int F_COV_EE = 3;
  localparam int F_COV_NE = 4;
  localparam int F_COV_NN = 5;
  localparam int F_COV_HE = 6;
  localparam int F_COV_HN = 7;
  localparam int F_COV_HH = 8;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] STS_STORED = 3'd0;
  localparam logic [2:0] STS_INVALID = 3'd1;
  localparam logic [2:0] STS_OLD = 3'd2;
  localparam logic [2:0] STS_OLD_CLEARED = 3'd3;
  localparam logic [2:0] STS_FOUND = 3'd4;
  localparam logic [2:0] STS_NOT_FOUND = 3'd5;
  localparam logic [2:0] STS_CLEARED = 3'd6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUEUE_SIZE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BAD_LIMIT = 2'd2;

  localparam int QUEUE_SIZE_RST = 100;
  localparam logic [7:0] QUEUE_SIZE_RST_V = 8'd100;
  localparam logic [31:0] MAX_OFFSET_RST = 32'd100000;
  localparam logic [7:0] BAD_LIMIT_RST = 8'd10;
  localparam logic [7:0] REJECT_SAT = 8'hFF;

endpackage

/* hw/rtl/tphr_rem.sv */
// Iterative remainder unit: num mod den, one restoring step per cycle.
// done pulses with rem valid after the last step. Uses no package.
module tphr_rem #(
  parameter int AW = 7,
  parameter int QW = AW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] num,
  input  logic [QW-1:0] den,
  output logic          done,
  output logic [QW-1:0] rem
);

  localparam int DW = QW + AW;
  localparam int CW = $clog2(AW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] x_r, x_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic          ge;

  assign ge = DW'(x_r) >= dv_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    dv_nxt   = dv_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(AW);
      x_nxt    = num;
      dv_nxt   = DW'(den) << AW;
    end else if (busy_r) begin
      if (ge) begin
        x_nxt = x_r - dv_r[QW-1:0];
      end
      dv_nxt = dv_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    dv_r <= dv_nxt;
  end

  assign done = done_r;
  assign rem  = x_r;

endmodule

/* hw/rtl/tphr_store.sv */
// Slot storage: stamp memory and record memory, one write and one read port each.
// Read data is registered and holds while the read enable is low. Uses no package.
module tphr_store #(
  parameter int DEPTH = 128,
  parameter int AW = 7,
  parameter int SW = 48,
  parameter int RW = 288
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [SW-1:0] wr_stamp,
  input  logic [RW-1:0] wr_rec,
  input  logic          st_re,
  input  logic [AW-1:0] st_raddr,
  output logic [SW-1:0] st_q,
  input  logic          rec_re,
  input  logic [AW-1:0] rec_raddr,
  output logic [RW-1:0] rec_q
);

  logic [SW-1:0] stamp_mem [DEPTH];
  logic [RW-1:0] rec_mem [DEPTH];
  logic [SW-1:0] st_q_r;
  logic [RW-1:0] rec_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
      rec_mem[wr_addr]   <= wr_rec;
    end
    if (st_re) begin
      st_q_r <= stamp_mem[st_raddr];
    end
    if (rec_re) begin
      rec_q_r <= rec_mem[rec_raddr];
    end
  end

  assign st_q  = st_q_r;
  assign rec_q = rec_q_r;

endmodule

/* hw/rtl/timestamped_pose_history_ring.sv */
// Timestamped pose history ring: top level with the sequencer and registers.
// Depends on tphr_pkg, tphr_rem and tphr_store.
//
// Usage: items enter on the in_ channel (valid/stall); each gives exactly one
// result on the out_ channel. Opcode push stores a pose record in the ring,
// lookup finds the newest stamp not after the asked time, clear empties it.
// The block works on one item at a time; in_stall is high while it is busy.
// After an input transfer the sequencer passes through the remainder step
// (S_MOD) and S_EXEC; a lookup on a non-empty ring then scans every filled
// slot (S_SCAN); every item ends in S_RD and S_CAP, where the result is loaded.
// The next transfer is taken in the cycle after the result is loaded.
// The remainder unit wraps the write pointer, and the scan reads one stamp a
// cycle from the stamp memory.
// A finished result waits in the output register; the next item may be taken
// meanwhile, and its result is held back until the previous one transfers.
// out_stall holds the result stable. Synchronous reset (rst_n low) empties
// the queue and loads the register defaults; no clearing pass is needed.
// Configuration writes (cfg_we) are meant for idle periods only.
module timestamped_pose_history_ring #(
  parameter int HISTORY_DEPTH = tphr_pkg::DEPTH_DEF,
  parameter int STAMP_BITS = tphr_pkg::STAMP_BITS_DEF,
  parameter int VALUE_BITS = tphr_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tphr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tphr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_opcode,
  input  logic                                in_entry_valid,
  input  logic [STAMP_BITS-1:0]               in_stamp,
  input  logic signed [VALUE_BITS-1:0]        in_east,
  input  logic signed [VALUE_BITS-1:0]        in_north,
  input  logic signed [VALUE_BITS-1:0]        in_heading,
  input  logic signed [VALUE_BITS-1:0]        in_cov_ee,
  input  logic signed [VALUE_BITS-1:0]        in_cov_ne,
  input  logic signed [VALUE_BITS-1:0]        in_cov_nn,
  input  logic signed [VALUE_BITS-1:0]        in_cov_he,
  input  logic signed [VALUE_BITS-1:0]        in_cov_hn,
  input  logic signed [VALUE_BITS-1:0]        in_cov_hh,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic [STAMP_BITS-1:0]               out_found_stamp,
  output logic signed [VALUE_BITS-1:0]        out_east,
  output logic signed [VALUE_BITS-1:0]        out_north,
  output logic signed [VALUE_BITS-1:0]        out_heading,
  output logic signed [VALUE_BITS-1:0]        out_cov_ee,
  output logic signed [VALUE_BITS-1:0]        out_cov_ne,
  output logic signed [VALUE_BITS-1:0]        out_cov_nn,
  output logic signed [VALUE_BITS-1:0]        out_cov_he,
  output logic signed [VALUE_BITS-1:0]        out_cov_hn,
  output logic signed [VALUE_BITS-1:0]        out_cov_hh,
  output logic [STAMP_BITS-1:0]               out_oldest_stamp
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int QW = AW + 1;
  localparam int XW = QW + 8;
  localparam int SW = STAMP_BITS;
  localparam int VB = VALUE_BITS;
  localparam int RW = tphr_pkg::NUM_VALUES * VB;
  localparam int RST_EFF = (tphr_pkg::QUEUE_SIZE_RST > HISTORY_DEPTH) ?
                           HISTORY_DEPTH : tphr_pkg::QUEUE_SIZE_RST;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOD  = 6'b000010,
    S_EXEC = 6'b000100,
    S_SCAN = 6'b001000,
    S_RD   = 6'b010000,
    S_CAP  = 6'b100000
  } tphr_state_t;

  tphr_state_t state_r, state_nxt;

  logic [7:0]    cfg_qsize_r;
  logic [31:0]   cfg_maxoff_r;
  logic [7:0]    cfg_limit_r;

  logic [AW-1:0] tail_r, tail_nxt;
  logic [QW-1:0] fill_r, fill_nxt;
  logic [7:0]    rej_r, rej_nxt;
  logic          oval_r, oval_nxt;

  logic [SW-1:0] newest_r, newest_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic          pushed_r, pushed_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          hit_r, hit_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [AW-1:0] hit_slot_r, hit_slot_nxt;
  logic [QW-1:0] scan_idx_r, scan_idx_nxt;
  logic [QW-1:0] n_r, n_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_slot_r, rd_slot_nxt;

  logic [1:0]    op_r;
  logic          ev_r;
  logic [SW-1:0] t_r;
  logic [RW-1:0] rec_in_r;

  logic [2:0]    ostat_r;
  logic [SW-1:0] ofound_r;
  logic [SW-1:0] ooldest_r;
  logic [RW-1:0] ovals_r;
  logic          load_out;

  logic          in_xfer;
  logic [XW-1:0] qs_ext;
  logic [QW-1:0] qs_eff;
  logic [QW-1:0] used_n;
  logic [QW-1:0] tail_inc;
  logic [7:0]    rej_inc;
  logic          scan_issue;

  logic          mod_start;
  logic          mod_done;
  logic [QW-1:0] mod_rem;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [SW-1:0] st_q;
  logic          rec_re;
  logic [RW-1:0] rec_q;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign qs_ext = XW'(cfg_qsize_r);
  always_comb begin
    if (cfg_qsize_r == 8'd0) begin
      qs_eff = QW'(1);
    end else if (qs_ext > XW'(HISTORY_DEPTH)) begin
      qs_eff = QW'(HISTORY_DEPTH);
    end else begin
      qs_eff = qs_ext[QW-1:0];
    end
  end

  assign used_n     = (fill_r < qs_eff) ? fill_r : qs_eff;
  assign tail_inc   = QW'(tail_r) + QW'(1);
  assign rej_inc    = (rej_r == tphr_pkg::REJECT_SAT) ? rej_r : rej_r + 8'd1;
  assign scan_issue = scan_idx_r < n_r;
  assign mod_start  = in_xfer;
  assign wr_addr    = (fill_r == '0) ? '0 : rem_r;
  assign load_out   = state_r[5] && (!oval_r || !out_stall);

  tphr_rem #(
    .AW (AW),
    .QW (QW)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (tail_inc),
    .den   (qs_eff),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  tphr_store #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW),
    .SW    (SW),
    .RW    (RW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_stamp  (t_r),
    .wr_rec    (rec_in_r),
    .st_re     (st_re),
    .st_raddr  (st_raddr),
    .st_q      (st_q),
    .rec_re    (rec_re),
    .rec_raddr (hit_slot_r),
    .rec_q     (rec_q)
  );

  always_comb begin
    state_nxt    = state_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    rej_nxt      = rej_r;
    oval_nxt     = oval_r && out_stall;
    newest_nxt   = newest_r;
    rem_nxt      = rem_r;
    pushed_nxt   = pushed_r;
    status_nxt   = status_r;
    hit_nxt      = hit_r;
    best_nxt     = best_r;
    hit_slot_nxt = hit_slot_r;
    scan_idx_nxt = scan_idx_r;
    n_nxt        = n_r;
    rd_vld_nxt   = 1'b0;
    rd_slot_nxt  = rd_slot_r;
    wr_en        = 1'b0;
    st_re        = 1'b0;
    st_raddr     = '0;
    rec_re       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          rem_nxt   = mod_rem[AW-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        hit_nxt      = 1'b0;
        hit_slot_nxt = '0;
        pushed_nxt   = 1'b0;
        state_nxt    = S_RD;
        case (op_r)
          tphr_pkg::OP_PUSH: begin
            if (!ev_r) begin
              status_nxt = tphr_pkg::STS_INVALID;
            end else if (fill_r != '0 && t_r < newest_r) begin
              if (rej_inc > cfg_limit_r) begin
                tail_nxt   = AW'(qs_eff - QW'(1));
                fill_nxt   = '0;
                rej_nxt    = 8'd0;
                status_nxt = tphr_pkg::STS_OLD_CLEARED;
              end else begin
                rej_nxt    = rej_inc;
                status_nxt = tphr_pkg::STS_OLD;
              end
            end else begin
              wr_en      = 1'b1;
              tail_nxt   = wr_addr;
              fill_nxt   = (fill_r >= qs_eff) ? qs_eff : fill_r + QW'(1);
              rej_nxt    = 8'd0;
              newest_nxt = t_r;
              pushed_nxt = 1'b1;
              status_nxt = tphr_pkg::STS_STORED;
            end
          end
          tphr_pkg::OP_LOOKUP: begin
            status_nxt = tphr_pkg::STS_NOT_FOUND;
            if (used_n != '0) begin
              n_nxt        = used_n;
              scan_idx_nxt = '0;
              state_nxt    = S_SCAN;
            end
          end
          tphr_pkg::OP_CLEAR: begin
            tail_nxt   = AW'(qs_eff - QW'(1));
            fill_nxt   = '0;
            rej_nxt    = 8'd0;
            status_nxt = tphr_pkg::STS_CLEARED;
          end
          default: begin
            status_nxt = tphr_pkg::STS_INVALID;
          end
        endcase
      end
      S_SCAN: begin
        st_re       = scan_issue;
        st_raddr    = scan_idx_r[AW-1:0];
        rd_vld_nxt  = scan_issue;
        rd_slot_nxt = scan_idx_r[AW-1:0];
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + QW'(1);
        end
        if (rd_vld_r && st_q <= t_r && (!hit_r || st_q > best_r)) begin
          hit_nxt      = 1'b1;
          best_nxt     = st_q;
          hit_slot_nxt = rd_slot_r;
        end
        if (!scan_issue && !rd_vld_r) begin
          state_nxt = S_RD;
          if (hit_r && (t_r - best_r) <= SW'(cfg_maxoff_r)) begin
            status_nxt = tphr_pkg::STS_FOUND;
          end else begin
            hit_nxt    = 1'b0;
            status_nxt = tphr_pkg::STS_NOT_FOUND;
          end
        end
      end
      S_RD: begin
        st_re  = 1'b1;
        rec_re = 1'b1;
        if (fill_r < qs_eff) begin
          st_raddr = '0;
        end else if (pushed_r) begin
          st_raddr = (tail_inc == qs_eff) ? '0 : tail_inc[AW-1:0];
        end else begin
          st_raddr = rem_r;
        end
        state_nxt = S_CAP;
      end
      S_CAP: begin
        if (load_out) begin
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tail_r       <= AW'(RST_EFF - 1);
      fill_r       <= '0;
      rej_r        <= 8'd0;
      oval_r       <= 1'b0;
      cfg_qsize_r  <= tphr_pkg::QUEUE_SIZE_RST_V;
      cfg_maxoff_r <= tphr_pkg::MAX_OFFSET_RST;
      cfg_limit_r  <= tphr_pkg::BAD_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      rej_r   <= rej_nxt;
      oval_r  <= oval_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tphr_pkg::CFG_QUEUE_SIZE: cfg_qsize_r  <= cfg_wdata[7:0];
          tphr_pkg::CFG_MAX_OFFSET: cfg_maxoff_r <= cfg_wdata;
          tphr_pkg::CFG_BAD_LIMIT:  cfg_limit_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    newest_r   <= newest_nxt;
    rem_r      <= rem_nxt;
    pushed_r   <= pushed_nxt;
    status_r   <= status_nxt;
    hit_r      <= hit_nxt;
    best_r     <= best_nxt;
    hit_slot_r <= hit_slot_nxt;
    scan_idx_r <= scan_idx_nxt;
    n_r        <= n_nxt;
    rd_vld_r   <= rd_vld_nxt;
    rd_slot_r  <= rd_slot_nxt;
    if (in_xfer) begin
      op_r     <= in_opcode;
      ev_r     <= in_entry_valid;
      t_r      <= in_stamp;
      rec_in_r <= {in_cov_hh, in_cov_hn, in_cov_he, in_cov_nn, in_cov_ne,
                   in_cov_ee, in_heading, in_north, in_east};
    end
    if (load_out) begin
      ostat_r   <= status_r;
      ofound_r  <= hit_r ? best_r : ((fill_r == '0) ? '0 : newest_r);
      ooldest_r <= (fill_r == '0) ? '1 : st_q;
      ovals_r   <= hit_r ? rec_q : '0;
    end
  end

  assign out_valid        = oval_r;
  assign out_status       = ostat_r;
  assign out_found_stamp  = ofound_r;
  assign out_oldest_stamp = ooldest_r;
  assign out_east    = $signed(ovals_r[tphr_pkg::F_EAST*VB +: VB]);
  assign out_north   = $signed(ovals_r[tphr_pkg::F_NORTH*VB +: VB]);
  assign out_heading = $signed(ovals_r[tphr_pkg::F_HEADING*VB +: VB]);
  assign out_cov_ee  = $signed(ovals_r[tphr_pkg::F_COV_EE*VB +: VB]);
  assign out_cov_ne  = $signed(ovals_r[tphr_pkg::F_COV_NE*VB +: VB]);
  assign out_cov_nn  = $signed(ovals_r[tphr_pkg::F_COV_NN*VB +: VB]);
  assign out_cov_he  = $signed(ovals_r[tphr_pkg::F_COV_HE*VB +: VB]);
  assign out_cov_hn  = $signed(ovals_r[tphr_pkg::F_COV_HN*VB +: VB]);
  assign out_cov_hh  = $signed(ovals_r[tphr_pkg::F_COV_HH*VB +: VB]);

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_xfer_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_MOD)
    else $error("input transfer did not start the remainder step");

  a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CAP && hit_r) |-> (fill_r != '0 && best_r <= t_r))
    else $error("lookup hit on an empty queue or after the asked time");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QW'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

endmodule
